>>> src/kcfr_pkg.sv
// Package for the keyed FIFO-replacement cache.
// Holds widths, defaults, codes, state encoding and the cell structs.
// No dependencies.
`default_nettype none

package kcfr_pkg;

  localparam int unsigned KCFR_ENTRIES = 16;
  localparam int unsigned KEY_W        = 64;
  localparam int unsigned VAL_W        = 64;
  localparam int unsigned CAP_W        = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } kcfr_func_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } kcfr_state_e;

  // one stored entry as it moves along the chain
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key_low;
    logic [KEY_W-1:0] key_high;
    logic [VAL_W-1:0] value;
  } kcfr_entry_t;

  // per-cell update control
  typedef struct packed {
    logic shift;
    logic write;
  } kcfr_cell_ctrl_t;

endpackage

`default_nettype wire

>>> src/kcfr_if.sv
// Request and response channel interfaces for the keyed cache.
// Depends on kcfr_pkg for field widths.
`default_nettype none

interface kcfr_req_if import kcfr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [KEY_W-1:0] key_low;
  logic [KEY_W-1:0] key_high;
  logic [VAL_W-1:0] write_value;

  modport source (output valid, func, key_low, key_high, write_value, input ready);
  modport sink   (input valid, func, key_low, key_high, write_value, output ready);
endinterface

interface kcfr_rsp_if import kcfr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [VAL_W-1:0] read_value;
  logic             evicted;

  modport source (output valid, hit, read_value, evicted, input ready);
  modport sink   (input valid, hit, read_value, evicted, output ready);
endinterface

`default_nettype wire

>>> src/kcfr_cell.sv
// One storage cell of the FIFO chain: holds an entry, compares it with the
// pending key, and takes a new entry or its younger neighbour's. Uses kcfr_pkg.
`default_nettype none

module kcfr_cell import kcfr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire kcfr_cell_ctrl_t  ctrl_i,
  input  wire kcfr_entry_t      new_i,
  input  wire kcfr_entry_t      next_i,
  input  wire logic [KEY_W-1:0] cmp_key_low_i,
  input  wire logic [KEY_W-1:0] cmp_key_high_i,
  output      kcfr_entry_t      entry_o,
  output      logic             match_o
);

  logic             valid_q, valid_d;
  logic [KEY_W-1:0] key_low_q, key_low_d;
  logic [KEY_W-1:0] key_high_q, key_high_d;
  logic [VAL_W-1:0] value_q, value_d;
  logic             match_q, match_d;

  // pick new entry, neighbour's entry, or hold
  always_comb begin
    priority if (ctrl_i.write) begin
      valid_d    = 1'b1;
      key_low_d  = new_i.key_low;
      key_high_d = new_i.key_high;
      value_d    = new_i.value;
    end else if (ctrl_i.shift) begin
      valid_d    = next_i.valid;
      key_low_d  = next_i.key_low;
      key_high_d = next_i.key_high;
      value_d    = next_i.value;
    end else begin
      valid_d    = valid_q;
      key_low_d  = key_low_q;
      key_high_d = key_high_q;
      value_d    = value_q;
    end
  end

  // compare the held key with the pending request
  assign match_d = valid_q && (key_low_q == cmp_key_low_i) && (key_high_q == cmp_key_high_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  // payload carries no reset
  always_ff @(posedge clk_i) begin
    key_low_q  <= key_low_d;
    key_high_q <= key_high_d;
    value_q    <= value_d;
  end

  assign entry_o = '{valid: valid_q, key_low: key_low_q, key_high: key_high_q,
                     value: value_q};
  assign match_o = match_q;

endmodule

`default_nettype wire

>>> src/keyed_cache_fifo_replacement.sv
// Top level of the fully associative keyed cache with FIFO replacement.
// Depends on kcfr_pkg, kcfr_req_if, kcfr_rsp_if and kcfr_cell.
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+---------------------------------------------
//  req     | in  | valid/ready  | func, key_low, key_high, write_value
//  rsp     | out | valid/ready  | hit, read_value, evicted
//  cfg     | in  | cfg_we_i     | cfg_wdata_i = capacity
//
// Each request passes S_CMP, the registered key compare in every cell, then
// S_UPD: hit reduction, result register load and shift or insert along the
// chain. A new request is taken only once the last one leaves S_UPD.
// Reset empties the store at once through the per-cell valid bits.
// A result waits in the output register; the next request is taken in the
// update cycle only when that register is free or being drained.
`default_nettype none

module keyed_cache_fifo_replacement import kcfr_pkg::*; #(
  parameter int unsigned ENTRIES = KCFR_ENTRIES
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  kcfr_req_if.sink              req,
  kcfr_rsp_if.source            rsp,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);

  kcfr_state_e state_q, state_d;

  logic [CAP_W-1:0] capacity_q;
  logic [CNT_W-1:0] count_q, count_d;

  logic             req_func_q;
  logic [KEY_W-1:0] req_key_low_q;
  logic [KEY_W-1:0] req_key_high_q;
  logic [VAL_W-1:0] req_value_q;

  logic             out_valid_q, out_valid_d;
  logic             out_hit_q;
  logic [VAL_W-1:0] out_value_q;
  logic             out_evicted_q;

  logic             accept;
  logic             finish;
  logic             hit;
  logic [VAL_W-1:0] hit_value;
  logic             is_put;
  logic             full;
  logic             insert;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] limit;
  logic [CNT_W-1:0] wpos;

  kcfr_entry_t      entries [ENTRIES+1];
  logic [ENTRIES-1:0] match;
  kcfr_entry_t      new_entry;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  // clamp capacity to the range the chain supports
  always_comb begin
    cap_ext = CMP_W'(capacity_q);
    priority if (cap_ext == '0) begin
      limit = CMP_W'(1);
    end else if (cap_ext > ENTRIES_C) begin
      limit = ENTRIES_C;
    end else begin
      limit = cap_ext;
    end
  end

  assign full   = CMP_W'(count_q) >= limit;
  assign is_put = (req_func_q == FUNC_PUT);
  assign wpos   = full ? (count_q - CNT_W'(1)) : count_q;

  // reduce the registered cell matches
  always_comb begin
    hit       = 1'b0;
    hit_value = '0;
    for (int i = 0; i < int'(ENTRIES); i++) begin
      hit       = hit | match[i];
      hit_value = hit_value | (match[i] ? entries[i].value : '0);
    end
  end

  // sequencer
  assign finish = (state_q == S_UPD) && (!out_valid_q || rsp.ready);
  assign accept = req.valid && req.ready;
  assign insert = finish && is_put && !hit;

  always_comb begin
    state_d   = state_q;
    req.ready = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) state_d = S_CMP;
      end
      S_CMP: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        req.ready = finish;
        if (finish) state_d = req.valid ? S_CMP : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // capture the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_func_q     <= req.func;
      req_key_low_q  <= req.key_low;
      req_key_high_q <= req.key_high;
      req_value_q    <= req.write_value;
    end
  end

  // fill count: grows only on an insert without eviction
  always_comb begin
    count_d = count_q;
    if (insert && !full) count_d = count_q + CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // cell chain, slot 0 the oldest
  assign new_entry = '{valid: 1'b1, key_low: req_key_low_q, key_high: req_key_high_q,
                       value: req_value_q};
  assign entries[ENTRIES] = '0;

  for (genvar g = 0; g < int'(ENTRIES); g++) begin : g_cell
    kcfr_cell_ctrl_t ctrl;
    assign ctrl.shift = insert && full;
    assign ctrl.write = insert && (wpos == CNT_W'(g));

    kcfr_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .new_i          (new_entry),
      .next_i         (entries[g+1]),
      .cmp_key_low_i  (req_key_low_q),
      .cmp_key_high_i (req_key_high_q),
      .entry_o        (entries[g]),
      .match_o        (match[g])
    );
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp.ready) out_valid_d = 1'b0;
    if (finish)    out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_hit_q     <= hit;
      out_value_q   <= (!is_put && hit) ? hit_value : '0;
      out_evicted_q <= is_put && !hit && full;
    end
  end

  assign rsp.valid      = out_valid_q;
  assign rsp.hit        = out_hit_q;
  assign rsp.read_value = out_value_q;
  assign rsp.evicted    = out_evicted_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(count_q) <= ENTRIES_C)
    else $error("fill count exceeds the number of cells");

  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.evicted) |-> !rsp.hit)
    else $error("eviction reported on a hit");

  a_value_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && (rsp.read_value != '0)) |-> rsp.hit)
    else $error("read value returned without a hit");

  a_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (insert && !full) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("fill count did not grow on insert");

  a_accept_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_CMP))
    else $error("accepted request did not enter compare");

endmodule

`default_nettype wire
